>>> rtl/bcsm_pkg.sv
`default_nettype none

package bcsm_pkg;

    localparam int SLOTS_DEFAULT = 64;

    localparam logic [6:0]  ENTRY_COUNT_RESET = 7'd64;
    localparam logic [15:0] REF_MAX           = 16'hFFFF;
    localparam logic [6:0]  TOTAL_MAX         = 7'd127;

    typedef enum logic [0:0] {
        ACT_ACQUIRE = 1'b0,
        ACT_RELEASE = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FINISH
    } fsm_state_t;

    typedef struct packed {
        action_t     action;
        logic [63:0] block_id;
        logic [7:0]  delay_value;
    } req_t;

    typedef struct packed {
        status_t    status;
        logic [5:0] slot_index;
        logic       is_new;
        logic       cache_full;
        logic [6:0] in_use_count;
        logic [6:0] peak_in_use;
    } rsp_t;

    // one slot as held in the table memory
    typedef struct packed {
        logic [63:0] block_id;
        logic [15:0] refcount;
        logic [31:0] stamp;
        logic [7:0]  delay_mark;
    } entry_t;

endpackage

`default_nettype wire

>>> rtl/bcsm_slot_ram.sv
`default_nettype none

module bcsm_slot_ram #(
    parameter int DEPTH = bcsm_pkg::SLOTS_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire bcsm_pkg::entry_t wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output bcsm_pkg::entry_t      rd_data
);

    bcsm_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/block_cache_slot_manager_unit.sv
`default_nettype none

// Channel   Handshake          Payload                 Direction
// request   start / busy       req (bcsm_pkg::req_t)   in
// result    done (one cycle)   rsp (bcsm_pkg::rsp_t)   out
// config    cfg_wr_en          cfg_wr_data (7 bits)    in
//
// A transaction reads the table once per live slot (the configured entry
// count, capped at SLOTS) through the single read port; once the last read
// has returned, the finish state writes the chosen slot back and registers the result.
// After reset every slot of the table is written to zero while busy is high.
// The result is shown on done for one cycle; the receiver cannot stall it.

module block_cache_slot_manager_unit #(
    parameter int SLOTS = bcsm_pkg::SLOTS_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire bcsm_pkg::req_t req,
    output logic                done,
    output bcsm_pkg::rsp_t      rsp,
    input  wire logic           cfg_wr_en,
    input  wire logic [6:0]     cfg_wr_data
);

    localparam int IDXW = $clog2(SLOTS);
    localparam int NW   = $clog2(SLOTS + 1);
    localparam int CMPW = (NW > 7) ? NW : 7;

    bcsm_pkg::fsm_state_t state_reg, state_next;

    logic [6:0]      entry_count_reg;
    logic [IDXW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [NW-1:0]   issue_cnt_reg, issue_cnt_next;
    logic            rvalid_reg, rvalid_next;
    logic [IDXW-1:0] ridx_reg, ridx_next;
    logic            found_reg, found_next;
    logic            have_reg, have_next;
    logic [31:0]     stamp_counter_reg, stamp_counter_next;
    logic [6:0]      total_reg, total_next;
    logic [6:0]      peak_reg, peak_next;
    logic            done_reg, done_next;

    bcsm_pkg::req_t   req_reg, req_next;
    logic [IDXW-1:0]  hit_idx_reg, hit_idx_next;
    bcsm_pkg::entry_t hit_ent_reg, hit_ent_next;
    logic [IDXW-1:0]  vic_idx_reg, vic_idx_next;
    logic [31:0]      vic_stamp_reg, vic_stamp_next;
    bcsm_pkg::rsp_t   rsp_reg, rsp_next;

    logic             ram_wr_en;
    logic [IDXW-1:0]  ram_wr_addr;
    bcsm_pkg::entry_t ram_wr_data;
    logic             ram_rd_en;
    logic [IDXW-1:0]  ram_rd_addr;
    bcsm_pkg::entry_t ram_rd_data;

    logic [CMPW-1:0] ec_wide;
    logic [NW-1:0]   n_live;

    assign ec_wide = CMPW'(entry_count_reg);
    assign n_live  = (ec_wide > CMPW'(SLOTS)) ? NW'(SLOTS) : NW'(entry_count_reg);

    bcsm_slot_ram #(
        .DEPTH (SLOTS),
        .AW    (IDXW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        logic            is_free;
        logic [6:0]      tot_up;
        logic [6:0]      tot_dn;
        logic [15:0]     new_ref;
        logic [7:0]      new_delay;
        logic [IDXW-1:0] res_idx;
        logic [IDXW+5:0] idx_wide;
        bcsm_pkg::status_t res_status;
        logic            res_new;

        state_next         = state_reg;
        clr_cnt_next       = clr_cnt_reg;
        issue_cnt_next     = issue_cnt_reg;
        rvalid_next        = 1'b0;
        ridx_next          = ridx_reg;
        found_next         = found_reg;
        have_next          = have_reg;
        stamp_counter_next = stamp_counter_reg;
        total_next         = total_reg;
        peak_next          = peak_reg;
        done_next          = 1'b0;
        req_next           = req_reg;
        hit_idx_next       = hit_idx_reg;
        hit_ent_next       = hit_ent_reg;
        vic_idx_next       = vic_idx_reg;
        vic_stamp_next     = vic_stamp_reg;
        rsp_next           = rsp_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = clr_cnt_reg;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = issue_cnt_reg[IDXW-1:0];

        is_free    = (ram_rd_data.refcount == 16'd0) && (ram_rd_data.delay_mark == 8'd0);
        tot_up     = (total_reg == bcsm_pkg::TOTAL_MAX) ? total_reg : total_reg + 7'd1;
        tot_dn     = (total_reg == 7'd0) ? total_reg : total_reg - 7'd1;
        new_ref    = hit_ent_reg.refcount;
        new_delay  = hit_ent_reg.delay_mark;
        res_idx    = '0;
        res_status = bcsm_pkg::ST_OK;
        res_new    = 1'b0;
        idx_wide   = '0;

        case (state_reg)
            bcsm_pkg::S_CLEAR:
            begin
                ram_wr_en    = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDXW'(SLOTS - 1))
                begin
                    state_next = bcsm_pkg::S_IDLE;
                end
            end

            bcsm_pkg::S_IDLE:
            begin
                if (start)
                begin
                    req_next       = req;
                    issue_cnt_next = '0;
                    found_next     = 1'b0;
                    have_next      = 1'b0;
                    state_next     = bcsm_pkg::S_SCAN;
                end
            end

            bcsm_pkg::S_SCAN:
            begin
                if (issue_cnt_reg < n_live)
                begin
                    ram_rd_en      = 1'b1;
                    rvalid_next    = 1'b1;
                    ridx_next      = issue_cnt_reg[IDXW-1:0];
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                if (rvalid_reg)
                begin
                    // first matching slot wins; a zero id never matches
                    if (!found_reg && req_reg.block_id != 64'd0
                        && ram_rd_data.block_id == req_reg.block_id)
                    begin
                        found_next   = 1'b1;
                        hit_idx_next = ridx_reg;
                        hit_ent_next = ram_rd_data;
                    end
                    // strict compare keeps the lowest index on a tie
                    if (is_free && (!have_reg || ram_rd_data.stamp < vic_stamp_reg))
                    begin
                        have_next      = 1'b1;
                        vic_idx_next   = ridx_reg;
                        vic_stamp_next = ram_rd_data.stamp;
                    end
                end
                else if (issue_cnt_reg == n_live)
                begin
                    state_next = bcsm_pkg::S_FINISH;
                end
            end

            bcsm_pkg::S_FINISH:
            begin
                if (req_reg.action == bcsm_pkg::ACT_ACQUIRE)
                begin
                    if (req_reg.block_id == 64'd0)
                    begin
                        res_status = bcsm_pkg::ST_NO_SPACE;
                    end
                    else if (found_reg)
                    begin
                        if (hit_ent_reg.refcount == 16'd0 && hit_ent_reg.delay_mark == 8'd0)
                        begin
                            total_next = tot_up;
                            peak_next  = (tot_up > peak_reg) ? tot_up : peak_reg;
                        end
                        if (hit_ent_reg.refcount != bcsm_pkg::REF_MAX)
                        begin
                            new_ref = hit_ent_reg.refcount + 16'd1;
                        end
                        stamp_counter_next     = stamp_counter_reg + 32'd1;
                        ram_wr_en              = 1'b1;
                        ram_wr_addr            = hit_idx_reg;
                        ram_wr_data            = hit_ent_reg;
                        ram_wr_data.refcount   = new_ref;
                        ram_wr_data.stamp      = stamp_counter_reg + 32'd1;
                        res_idx                = hit_idx_reg;
                    end
                    else if (have_reg)
                    begin
                        total_next             = tot_up;
                        peak_next              = (tot_up > peak_reg) ? tot_up : peak_reg;
                        stamp_counter_next     = stamp_counter_reg + 32'd1;
                        ram_wr_en              = 1'b1;
                        ram_wr_addr            = vic_idx_reg;
                        ram_wr_data.block_id   = req_reg.block_id;
                        ram_wr_data.refcount   = 16'd1;
                        ram_wr_data.stamp      = stamp_counter_reg + 32'd1;
                        ram_wr_data.delay_mark = 8'd0;
                        res_idx                = vic_idx_reg;
                        res_new                = 1'b1;
                    end
                    else
                    begin
                        res_status = bcsm_pkg::ST_NO_SPACE;
                    end
                end
                else
                begin
                    if (!found_reg)
                    begin
                        res_status = bcsm_pkg::ST_NOT_FOUND;
                    end
                    else
                    begin
                        if (hit_ent_reg.refcount != 16'd0)
                        begin
                            new_ref = hit_ent_reg.refcount - 16'd1;
                        end
                        if (req_reg.delay_value != 8'd0)
                        begin
                            new_delay = req_reg.delay_value;
                        end
                        // only a referenced slot that ends unreferenced and undelayed
                        if (hit_ent_reg.refcount != 16'd0 && new_ref == 16'd0
                            && new_delay == 8'd0)
                        begin
                            total_next = tot_dn;
                        end
                        ram_wr_en              = 1'b1;
                        ram_wr_addr            = hit_idx_reg;
                        ram_wr_data            = hit_ent_reg;
                        ram_wr_data.refcount   = new_ref;
                        ram_wr_data.delay_mark = new_delay;
                        res_idx                = hit_idx_reg;
                    end
                end

                idx_wide              = (IDXW + 6)'(res_idx);
                rsp_next.status       = res_status;
                rsp_next.slot_index   = idx_wide[5:0];
                rsp_next.is_new       = res_new;
                rsp_next.cache_full   = (CMPW'(total_next) == CMPW'(n_live));
                rsp_next.in_use_count = total_next;
                rsp_next.peak_in_use  = peak_next;
                done_next             = 1'b1;
                state_next            = bcsm_pkg::S_IDLE;
            end

            default:
            begin
                state_next = bcsm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= bcsm_pkg::S_CLEAR;
            entry_count_reg   <= bcsm_pkg::ENTRY_COUNT_RESET;
            clr_cnt_reg       <= '0;
            issue_cnt_reg     <= '0;
            rvalid_reg        <= 1'b0;
            found_reg         <= 1'b0;
            have_reg          <= 1'b0;
            stamp_counter_reg <= '0;
            total_reg         <= '0;
            peak_reg          <= '0;
            done_reg          <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            clr_cnt_reg       <= clr_cnt_next;
            issue_cnt_reg     <= issue_cnt_next;
            rvalid_reg        <= rvalid_next;
            found_reg         <= found_next;
            have_reg          <= have_next;
            stamp_counter_reg <= stamp_counter_next;
            total_reg         <= total_next;
            peak_reg          <= peak_next;
            done_reg          <= done_next;
            if (cfg_wr_en)
            begin
                entry_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        ridx_reg      <= ridx_next;
        hit_idx_reg   <= hit_idx_next;
        hit_ent_reg   <= hit_ent_next;
        vic_idx_reg   <= vic_idx_next;
        vic_stamp_reg <= vic_stamp_next;
        rsp_reg       <= rsp_next;
    end

    assign busy = (state_reg != bcsm_pkg::S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

>>> tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          SLOT_DEPTH  = bcsm_pkg::SLOTS_DEFAULT;
    localparam int          CYCLE_LIMIT = 4_000_000;

    class slot_scoreboard;
        logic [63:0] blk_ids    [SLOT_DEPTH];
        logic [15:0] ref_cnt    [SLOT_DEPTH];
        logic [31:0] lru_stamp  [SLOT_DEPTH];
        logic [7:0]  delay_mark [SLOT_DEPTH];
        logic [31:0] stamp_ctr;
        logic [6:0]  in_use;
        logic [6:0]  in_use_peak;
        logic [6:0]  entries;
        bcsm_pkg::rsp_t expected_rsp [$];
        int          fails;
        int          checked;
        int          hits;
        int          fresh;
        int          refused;
        int          not_found;

        function new();
            for (int i = 0; i < SLOT_DEPTH; i++)
            begin
                blk_ids[i]    = '0;
                ref_cnt[i]    = '0;
                lru_stamp[i]  = '0;
                delay_mark[i] = '0;
            end
            stamp_ctr   = '0;
            in_use      = '0;
            in_use_peak = '0;
            entries     = bcsm_pkg::ENTRY_COUNT_RESET;
            fails       = 0;
            checked     = 0;
            hits        = 0;
            fresh       = 0;
            refused     = 0;
            not_found   = 0;
        endfunction

        function void set_entries(logic [6:0] v);
            entries = v;
        endfunction

        function void raise_in_use();
            if (in_use < bcsm_pkg::TOTAL_MAX)
                in_use++;
            if (in_use > in_use_peak)
                in_use_peak = in_use;
        endfunction

        function void note_request(bcsm_pkg::req_t r);
            int unsigned       n;
            int unsigned       slot;
            int unsigned       best;
            logic [31:0]       best_stamp;
            bit                found;
            bit                have;
            bit                was_ref;
            bcsm_pkg::status_t st;
            bcsm_pkg::rsp_t    e;
            n          = (entries > SLOT_DEPTH) ? SLOT_DEPTH : entries;
            slot       = 0;
            best       = 0;
            best_stamp = '0;
            found      = 1'b0;
            have       = 1'b0;
            st         = bcsm_pkg::ST_OK;
            e          = '0;
            for (int unsigned i = 0; i < n; i++)
            begin
                if (!found && r.block_id != 64'd0 && blk_ids[i] == r.block_id)
                begin
                    found = 1'b1;
                    slot  = i;
                end
            end
            if (r.action == bcsm_pkg::ACT_ACQUIRE)
            begin
                if (r.block_id == 64'd0)
                begin
                    st = bcsm_pkg::ST_NO_SPACE;
                end
                else if (found)
                begin
                    hits++;
                    if (ref_cnt[slot] == 16'd0 && delay_mark[slot] == 8'd0)
                        raise_in_use();
                    if (ref_cnt[slot] != bcsm_pkg::REF_MAX)
                        ref_cnt[slot]++;
                    stamp_ctr++;
                    lru_stamp[slot] = stamp_ctr;
                end
                else
                begin
                    // victim: oldest slot neither referenced nor delayed, lowest index on a tie
                    for (int unsigned i = 0; i < n; i++)
                    begin
                        if (ref_cnt[i] == 16'd0 && delay_mark[i] == 8'd0 &&
                            (!have || lru_stamp[i] < best_stamp))
                        begin
                            have       = 1'b1;
                            best       = i;
                            best_stamp = lru_stamp[i];
                        end
                    end
                    if (have)
                    begin
                        slot             = best;
                        blk_ids[slot]    = r.block_id;
                        ref_cnt[slot]    = 16'd1;
                        stamp_ctr++;
                        lru_stamp[slot]  = stamp_ctr;
                        raise_in_use();
                        e.is_new         = 1'b1;
                        fresh++;
                    end
                    else
                    begin
                        st = bcsm_pkg::ST_NO_SPACE;
                    end
                end
            end
            else
            begin
                if (!found)
                begin
                    st = bcsm_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    was_ref = (ref_cnt[slot] != 16'd0);
                    if (was_ref)
                        ref_cnt[slot]--;
                    if (r.delay_value != 8'd0)
                        delay_mark[slot] = r.delay_value;
                    if (was_ref && ref_cnt[slot] == 16'd0 && delay_mark[slot] == 8'd0 &&
                        in_use != 7'd0)
                        in_use--;
                end
            end
            if (st == bcsm_pkg::ST_NO_SPACE)
                refused++;
            if (st == bcsm_pkg::ST_NOT_FOUND)
                not_found++;
            e.status       = st;
            e.slot_index   = (st == bcsm_pkg::ST_OK) ? 6'(slot) : 6'd0;
            e.cache_full   = (in_use == n);
            e.in_use_count = in_use;
            e.peak_in_use  = in_use_peak;
            expected_rsp.push_back(e);
        endfunction

        function void check_result(bcsm_pkg::rsp_t got);
            bcsm_pkg::rsp_t want;
            if (expected_rsp.size() == 0)
            begin
                $error("result with no transaction outstanding: status %0d slot %0d",
                       got.status, got.slot_index);
                fails++;
                return;
            end
            want = expected_rsp.pop_front();
            checked++;
            if (got.status != want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                fails++;
            end
            if (got.slot_index != want.slot_index)
            begin
                $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
                fails++;
            end
            if (got.is_new != want.is_new)
            begin
                $error("is_new: expected %0d, got %0d", want.is_new, got.is_new);
                fails++;
            end
            if (got.cache_full != want.cache_full)
            begin
                $error("cache_full: expected %0d, got %0d", want.cache_full, got.cache_full);
                fails++;
            end
            if (got.in_use_count != want.in_use_count)
            begin
                $error("in_use_count: expected %0d, got %0d",
                       want.in_use_count, got.in_use_count);
                fails++;
            end
            if (got.peak_in_use != want.peak_in_use)
            begin
                $error("peak_in_use: expected %0d, got %0d",
                       want.peak_in_use, got.peak_in_use);
                fails++;
            end
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    bcsm_pkg::req_t req;
    logic           done;
    bcsm_pkg::rsp_t rsp;
    logic           cfg_wr_en;
    logic [6:0]     cfg_wr_data;

    slot_scoreboard sb;
    int             cycles = 0;
    int unsigned    burst_left = 0;
    int unsigned    phase_entries [8] = '{5, 1, 2, 16, 64, 127, 33, 64};

    block_cache_slot_manager_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .done        (done),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // results are checked before a transaction accepted on the same edge is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(rsp);
            if (start && !busy)
                sb.note_request(req);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic bcsm_pkg::req_t mk_req(bcsm_pkg::action_t act, logic [63:0] id,
                                              logic [7:0] dly);
        bcsm_pkg::req_t r;
        r.action      = act;
        r.block_id    = id;
        r.delay_value = dly;
        return r;
    endfunction

    // mostly random gaps, with occasional back-to-back stretches
    function automatic int draw_gap();
        if (burst_left != 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            burst_left = $urandom_range(10, 40);
        return $urandom_range(0, 16);
    endfunction

    task automatic send(input bcsm_pkg::req_t r, input bit back_to_back);
        int gap;
        gap = back_to_back ? 0 : draw_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge clk);
        while (sb.expected_rsp.size() != 0 || busy) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_entries(input logic [6:0] v);
        wait_quiet();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_entries(v);
    endtask

    function automatic logic [63:0] rand_id();
        logic [63:0] id;
        id = {$urandom, $urandom};
        return (id == 64'd0) ? 64'd1 : id;
    endfunction

    function automatic logic [7:0] rand_delay();
        return ($urandom_range(0, 59) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
    endfunction

    task automatic run_phase(input int unsigned entries, input int unsigned count);
        logic [63:0]    pool [$];
        logic [63:0]    held [$];
        int unsigned    pool_n;
        int unsigned    live_n;
        int unsigned    p;
        int unsigned    j;
        bcsm_pkg::req_t r;
        write_entries(entries[6:0]);
        live_n = (entries > SLOT_DEPTH) ? SLOT_DEPTH : entries;
        pool_n = 2 * live_n + 2;
        for (int unsigned k = 0; k < pool_n; k++)
            pool.push_back(rand_id());
        for (int unsigned k = 0; k < count; k++)
        begin
            p = $urandom_range(0, 99);
            if (p < 48)
            begin
                r = mk_req(bcsm_pkg::ACT_ACQUIRE, pool[$urandom_range(0, pool_n - 1)],
                           8'($urandom));
                held.push_back(r.block_id);
            end
            else if (p < 88 && held.size() != 0)
            begin
                j = $urandom_range(0, held.size() - 1);
                r = mk_req(bcsm_pkg::ACT_RELEASE, held[j], rand_delay());
                held.delete(j);
            end
            else if (p < 94)
            begin
                r = mk_req(bcsm_pkg::ACT_RELEASE, pool[$urandom_range(0, pool_n - 1)],
                           rand_delay());
            end
            else if (p < 97)
            begin
                // stray ids, mostly missing
                r = mk_req(bcsm_pkg::action_t'($urandom_range(0, 1)), rand_id(), rand_delay());
                if (r.action == bcsm_pkg::ACT_ACQUIRE)
                    held.push_back(r.block_id);
            end
            else
            begin
                r = mk_req(bcsm_pkg::action_t'($urandom_range(0, 1)), 64'd0, 8'($urandom));
            end
            send(r, 1'b0);
        end
        // hand back whatever is still held so later phases start with no slot still referenced
        while (held.size() != 0)
            send(mk_req(bcsm_pkg::ACT_RELEASE, held.pop_front(), 8'd0), 1'b0);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        req         = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        sb          = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        wait_quiet();

        // directed: reset entry count
        send(mk_req(bcsm_pkg::ACT_ACQUIRE, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0), 1'b0);
        send(mk_req(bcsm_pkg::ACT_ACQUIRE, 64'd1, 8'd0), 1'b0);
        send(mk_req(bcsm_pkg::ACT_ACQUIRE, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0), 1'b0);
        send(mk_req(bcsm_pkg::ACT_RELEASE, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0), 1'b0);
        send(mk_req(bcsm_pkg::ACT_RELEASE, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0), 1'b0);
        // already unreferenced
        send(mk_req(bcsm_pkg::ACT_RELEASE, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0), 1'b0);
        send(mk_req(bcsm_pkg::ACT_RELEASE, 64'd1, 8'hFF), 1'b0);
        // hit on a delayed, unreferenced slot
        send(mk_req(bcsm_pkg::ACT_ACQUIRE, 64'd1, 8'd0), 1'b0);
        send(mk_req(bcsm_pkg::ACT_RELEASE, 64'd1, 8'd0), 1'b0);
        send(mk_req(bcsm_pkg::ACT_ACQUIRE, 64'd0, 8'hFF), 1'b0);
        send(mk_req(bcsm_pkg::ACT_RELEASE, 64'd0, 8'hFF), 1'b0);
        send(mk_req(bcsm_pkg::ACT_RELEASE, 64'd12345, 8'd0), 1'b0);
        send(mk_req(bcsm_pkg::ACT_ACQUIRE, 64'h8000_0000_0000_0000, 8'd0), 1'b0);

        // two live slots: eviction, refusal, full flag
        write_entries(7'd2);
        send(mk_req(bcsm_pkg::ACT_ACQUIRE, 64'h0123_4567_89AB_CDEF, 8'd0), 1'b0);
        send(mk_req(bcsm_pkg::ACT_ACQUIRE, 64'h7654_3210_FEDC_BA98, 8'd0), 1'b0);
        send(mk_req(bcsm_pkg::ACT_RELEASE, 64'h0123_4567_89AB_CDEF, 8'd0), 1'b0);
        send(mk_req(bcsm_pkg::ACT_ACQUIRE, 64'h7654_3210_FEDC_BA98, 8'd0), 1'b0);
        send(mk_req(bcsm_pkg::ACT_RELEASE, 64'h7654_3210_FEDC_BA98, 8'd0), 1'b0);
        send(mk_req(bcsm_pkg::ACT_RELEASE, 64'h8000_0000_0000_0000, 8'd0), 1'b0);

        // above the built depth acts as full depth
        write_entries(7'd127);
        send(mk_req(bcsm_pkg::ACT_RELEASE, 64'h8000_0000_0000_0000, 8'd0), 1'b0);
        send(mk_req(bcsm_pkg::ACT_ACQUIRE, 64'h5555_AAAA_5555_AAAA, 8'd0), 1'b0);
        send(mk_req(bcsm_pkg::ACT_RELEASE, 64'h5555_AAAA_5555_AAAA, 8'd0), 1'b0);

        // no live slots at all
        write_entries(7'd0);
        send(mk_req(bcsm_pkg::ACT_ACQUIRE, 64'h0123_4567_89AB_CDEF, 8'd0), 1'b0);
        send(mk_req(bcsm_pkg::ACT_RELEASE, 64'd1, 8'd7), 1'b0);

        foreach (phase_entries[i])
            run_phase(phase_entries[i], 190);

        wait_quiet();
        repeat (SLOT_DEPTH + 8) @(posedge clk);
        if (sb.expected_rsp.size() != 0)
        begin
            $error("%0d results never arrived", sb.expected_rsp.size());
            sb.fails++;
        end
        $display("summary: %0d transactions checked: %0d hits, %0d fresh slots,",
                 sb.checked, sb.hits, sb.fresh);
        $display("summary: %0d refused, %0d not found, entry counts 0 to 127 exercised",
                 sb.refused, sb.not_found);
        if (sb.fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
